// ===== hw/rtl/signed_word_sort_engine_defines.svh =====
// assertion macros for the signed word sort engine checker
// no dependencies
`ifndef SIGNED_WORD_SORT_ENGINE_DEFINES_SVH
`define SIGNED_WORD_SORT_ENGINE_DEFINES_SVH
// assert that an antecedent implies a consequent on the next edge
`define SWS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("label failed");
// assert that an expression holds at every edge
`define SWS_ASSERT_ALWAYS(label, clk, rst_n, e) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (e)) \
        else $error("label failed");
`endif

// ===== hw/rtl/sws_pkg.sv =====
// shared constants and types for the signed word sort engine
// no dependencies
package sws_pkg;
    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int STACK_DEPTH = 64;
    localparam int SP_W = $clog2(STACK_DEPTH) + 1;
    localparam int WORD_W = 32;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } range_t;
endpackage

// ===== hw/rtl/sws_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sws_cmp.sv =====
// shared signed compare unit for the partition loop
// depends on sws_pkg
module sws_cmp
    import sws_pkg::*;
(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              lt,
    output logic              eq
);
    assign lt = $signed(a) < $signed(b);
    assign eq = a == b;
endmodule

// ===== hw/rtl/signed_word_sort_engine.sv =====
// top level of the signed word sort engine: loader, sort sequencer, output
// depends on sws_pkg, sws_ram, sws_cmp
// operation: loading takes one item per cycle; a marked item starts the sort: the
// set is seeded as a range on the stack, ranges are popped and partitioned, each
// scanned word is compared and then rotated (less), written (equal) or passed over
// (greater); results then go out one per cycle while the sink is ready; the input
// is not ready from the marked item until the final result
// reset: the item count, stack pointer, overflow flag and the sequencer clear
// asynchronously; the element store and the range stack hold anything until written
module signed_word_sort_engine
    import sws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sorted_value[31:0]
    output logic        m_tlast,   // last_out
    output logic        m_tuser    // overflowed
);
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SEED  = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_RANGE = 4'd3;
    localparam logic [3:0] ST_PIV   = 4'd4;
    localparam logic [3:0] ST_CVAL  = 4'd5;
    localparam logic [3:0] ST_CLS   = 4'd6;
    localparam logic [3:0] ST_ROT1  = 4'd7;
    localparam logic [3:0] ST_ROT2  = 4'd8;
    localparam logic [3:0] ST_ROT3  = 4'd9;
    localparam logic [3:0] ST_WEQ   = 4'd10;
    localparam logic [3:0] ST_NEXT  = 4'd11;
    localparam logic [3:0] ST_PUSHL = 4'd12;
    localparam logic [3:0] ST_PUSHR = 4'd13;
    localparam logic [3:0] ST_ORD   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [IDX_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]  lt_reg, lt_next, eq_reg, eq_next;
    logic [CNT_W-1:0]  c_reg, c_next;     // scan index, also output index
    logic [WORD_W-1:0] piv_reg, piv_next;
    logic [WORD_W-1:0] cval_reg, cval_next, hold_reg, hold_next;
    logic              cmp_lt, cmp_eq;

    // element store port controls
    logic              st_we;
    logic [IDX_W-1:0]  st_waddr, st_raddr;
    logic [WORD_W-1:0] st_wdata, st_rdata;
    // range stack port controls
    logic              rs_we;
    logic [SP_W-2:0]   rs_waddr, rs_raddr;
    range_t            rs_wdata, rs_rdata;

    logic [IDX_W:0]    mid_sum;
    logic              stack_room;

    sws_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ELEMENTS)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    sws_ram #(.WIDTH($bits(range_t)), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    // the one compare unit, fed with the word under scan and the pivot
    sws_cmp u_cmp (.a(cval_reg), .b(piv_reg), .lt(cmp_lt), .eq(cmp_eq));

    assign s_tready   = state_reg == ST_LOAD;
    assign m_tvalid   = state_reg == ST_OUT;
    // store read port keeps the output address while the result waits
    assign m_tdata    = st_rdata;
    assign m_tlast    = c_reg == count_reg - CNT_W'(1);
    assign m_tuser    = ovf_reg;
    // middle of the popped range, straight from the stack read data
    assign mid_sum    = {1'b0, rs_rdata.lo} + {1'b0, rs_rdata.hi};
    assign stack_room = sp_reg < SP_W'(STACK_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        sp_next = sp_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        lt_next = lt_reg;
        eq_next = eq_reg;
        c_next = c_reg;
        piv_next = piv_reg;
        cval_next = cval_reg;
        hold_next = hold_reg;
        st_we = 1'b0;
        st_waddr = c_reg[IDX_W-1:0];
        st_wdata = cval_reg;
        st_raddr = c_reg[IDX_W-1:0];
        rs_we = 1'b0;
        rs_waddr = sp_reg[SP_W-2:0];
        rs_wdata = '{lo: lo_reg, hi: hi_reg};
        rs_raddr = sp_reg[SP_W-2:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        st_we = 1'b1;
                        st_waddr = count_reg[IDX_W-1:0];
                        st_wdata = s_tdata;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // store full, the item is dropped
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                // whole set as the first range, only when two or more words
                sp_next = '0;
                if (count_reg >= CNT_W'(2))
                begin
                    rs_we = 1'b1;
                    rs_waddr = '0;
                    rs_wdata = '{lo: '0, hi: IDX_W'(count_reg - CNT_W'(1))};
                    sp_next = SP_W'(1);
                end
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    c_next = '0;
                    state_next = ST_ORD;
                end
                else
                begin
                    sp_next = sp_reg - SP_W'(1);
                    rs_raddr = sp_next[SP_W-2:0];
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                lo_next = rs_rdata.lo;
                hi_next = rs_rdata.hi;
                if ({1'b0, rs_rdata.hi} >= count_reg || rs_rdata.lo >= rs_rdata.hi)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    st_raddr = mid_sum[IDX_W:1];
                    state_next = ST_PIV;
                end
            end
            ST_PIV:
            begin
                // pivot word arrives, start the scan at lo
                piv_next = st_rdata;
                lt_next = {1'b0, lo_reg};
                eq_next = {1'b0, lo_reg};
                c_next = {1'b0, lo_reg};
                st_raddr = lo_reg;
                state_next = ST_CVAL;
            end
            ST_CVAL:
            begin
                cval_next = st_rdata;
                st_raddr = eq_reg[IDX_W-1:0];
                state_next = ST_CLS;
            end
            ST_CLS:
            begin
                // st_rdata is store[eq]
                hold_next = st_rdata;
                if (cmp_lt)
                begin
                    st_raddr = lt_reg[IDX_W-1:0];
                    state_next = ST_ROT1;
                end
                else if (cmp_eq)
                begin
                    st_we = 1'b1;
                    st_waddr = c_reg[IDX_W-1:0];
                    st_wdata = st_rdata;
                    state_next = ST_WEQ;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_ROT1:
            begin
                // rotation: store[c] gets old store[eq], st_rdata is old store[lt]
                st_we = 1'b1;
                st_waddr = c_reg[IDX_W-1:0];
                st_wdata = hold_reg;
                hold_next = st_rdata;
                state_next = ST_ROT2;
            end
            ST_ROT2:
            begin
                st_we = 1'b1;
                st_waddr = eq_reg[IDX_W-1:0];
                st_wdata = hold_reg;
                state_next = ST_ROT3;
            end
            ST_ROT3:
            begin
                st_we = 1'b1;
                st_waddr = lt_reg[IDX_W-1:0];
                st_wdata = cval_reg;
                lt_next = lt_reg + CNT_W'(1);
                eq_next = eq_reg + CNT_W'(1);
                state_next = ST_NEXT;
            end
            ST_WEQ:
            begin
                st_we = 1'b1;
                st_waddr = eq_reg[IDX_W-1:0];
                st_wdata = cval_reg;
                eq_next = eq_reg + CNT_W'(1);
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (c_reg == {1'b0, hi_reg})
                begin
                    state_next = ST_PUSHL;
                end
                else
                begin
                    c_next = c_reg + CNT_W'(1);
                    st_raddr = c_next[IDX_W-1:0];
                    state_next = ST_CVAL;
                end
            end
            ST_PUSHL:
            begin
                // less-than part when it holds two or more words and the stack has room
                if (lt_reg > {1'b0, lo_reg} + CNT_W'(1) && stack_room)
                begin
                    rs_we = 1'b1;
                    rs_wdata = '{lo: lo_reg, hi: IDX_W'(lt_reg - CNT_W'(1))};
                    sp_next = sp_reg + SP_W'(1);
                end
                state_next = ST_PUSHR;
            end
            ST_PUSHR:
            begin
                // greater-than part when it holds two or more words and the stack has room
                if (eq_reg < {1'b0, hi_reg} && stack_room)
                begin
                    rs_we = 1'b1;
                    rs_wdata = '{lo: eq_reg[IDX_W-1:0], hi: hi_reg};
                    sp_next = sp_reg + SP_W'(1);
                end
                state_next = ST_POP;
            end
            ST_ORD:
            begin
                // first output word is read at c = 0
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (m_tlast)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        c_next = c_reg + CNT_W'(1);
                        st_raddr = c_next[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        lt_reg <= lt_next;
        eq_reg <= eq_next;
        c_reg <= c_next;
        piv_reg <= piv_next;
        cval_reg <= cval_next;
        hold_reg <= hold_next;
    end
endmodule

// ===== hw/rtl/sws_checker.sv =====
// port-level checker for the signed word sort engine, bound to the top level
// depends on signed_word_sort_engine_defines.svh
`include "signed_word_sort_engine_defines.svh"
module sws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    // no loading while results are offered
    `SWS_ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(s_tready && m_tvalid))
    // a stalled result keeps its data
    `SWS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // the final result returns the block to loading
    `SWS_ASSERT_NEXT(a_end, clk, rst_n, m_tvalid && m_tready && m_tlast, s_tready)
    // overflow flag stays constant across a run
    `SWS_ASSERT_NEXT(a_ovf, clk, rst_n, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || m_tuser == $past(m_tuser))
endmodule

bind signed_word_sort_engine sws_checker u_sws_checker (.*);

// ===== bench/signed_word_sort_engine_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the signed word sort engine: streams word sets in,
// predicts the sorted output with a three-way quicksort, and checks every word
// depends on sws_pkg and the signed_word_sort_engine rtl
module signed_word_sort_engine_test;
    import sws_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic        last;
        logic        ovf;
    } sorted_word_t;

    // scoreboard: collects the current set, sorts it on the marked item
    class sort_scoreboard;
        logic [31:0]  set_words[$];
        bit           set_ovf;
        sorted_word_t pending[$];
        int           errors;
        int           checked;
        int           sets;

        // three-way partition quicksort on signed words, explicit range stack
        function void sort_set();
            int lo_q[$];
            int hi_q[$];
            int lo, hi, lt, eq, c;
            logic signed [31:0] pv, v, t;
            lo_q.push_back(0);
            hi_q.push_back(set_words.size() - 1);
            while (lo_q.size() > 0)
            begin
                lo = lo_q.pop_back();
                hi = hi_q.pop_back();
                if (lo >= hi)
                    continue;
                pv = set_words[lo + (hi - lo) / 2];
                lt = lo;
                eq = lo;
                for (c = lo; c <= hi; c++)
                begin
                    v = set_words[c];
                    if (v < pv)
                    begin
                        t = set_words[c];
                        set_words[c] = set_words[eq];
                        set_words[eq] = set_words[lt];
                        set_words[lt] = t;
                        lt++;
                        eq++;
                    end
                    else if (v == pv)
                    begin
                        t = set_words[eq];
                        set_words[eq] = set_words[c];
                        set_words[c] = t;
                        eq++;
                    end
                end
                if (lt > lo + 1)
                begin
                    lo_q.push_back(lo);
                    hi_q.push_back(lt - 1);
                end
                if (eq < hi)
                begin
                    lo_q.push_back(eq);
                    hi_q.push_back(hi);
                end
            end
        endfunction

        function void note_item(logic [31:0] value, logic last_item);
            sorted_word_t r;
            if (set_words.size() < MAX_ELEMENTS)
                set_words.push_back(value);
            else
                set_ovf = 1;
            if (!last_item)
                return;
            sort_set();
            foreach (set_words[k])
            begin
                r.word = set_words[k];
                r.last = (k == set_words.size() - 1);
                r.ovf  = set_ovf;
                pending.push_back(r);
            end
            set_words.delete();
            set_ovf = 0;
            sets++;
        endfunction

        function void check_result(logic [31:0] word, logic last, logic ovf);
            sorted_word_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected item word=%h last=%b ovf=%b",
                         $time, word, last, ovf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (word !== e.word)
            begin
                $display("%0t: sorted_value expected %h actual %h", $time, e.word, word);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last_out expected %b actual %b", $time, e.last, last);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t: overflowed expected %b actual %b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value[31:0]
    logic        s_tlast;   // last_item
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // sorted_value[31:0]
    logic        m_tlast;   // last_out
    logic        m_tuser;   // overflowed

    sort_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    signed_word_sort_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // scoreboard sampling and no-progress watchdog on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tlast, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // receiver: random stalls, or a full hold-off while pressure is applied
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one item, with random idle cycles before it; valid stays up after
    // the accept until the next item or an idle cycle replaces it
    task send_item(input logic [31:0] value, input logic last_item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= value;
        s_tlast  <= last_item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly mid-range, sometimes extremes and small repeating values
    function logic [31:0] pick_word();
        case ($urandom_range(3))
            0: pick_word = $urandom_range(7) - 4;
            1: pick_word = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: pick_word = $urandom;
        endcase
    endfunction

    // one set of n words, the last one marked
    task send_set(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_word(), i == n - 1);
    endtask

    task drain();
        s_tvalid <= 0;
        while (board.pending.size() > 0 && !timed_out)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    // stop the run if nothing is accepted for too long
    initial
    begin
        timed_out = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_cycles > 200000)
            begin
                timed_out = 1;
                $display("%0t: watchdog expired", $time);
                $display("signed_word_sort_engine_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        hold_off = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: single words at the extremes, duplicates, sorted inputs
        send_item(32'h8000_0000, 1);
        send_item(32'h7fff_ffff, 1);
        send_item(32'h7fff_ffff, 0);
        send_item(32'h8000_0000, 0);
        send_item(32'h0000_0000, 0);
        send_item(32'hffff_ffff, 1);
        send_item(32'h5555_5555, 0);
        send_item(32'haaaa_aaaa, 0);
        send_item(32'h5555_5555, 1);
        for (int i = 0; i < 5; i++)
            send_item(i, i == 4);
        for (int i = 0; i < 5; i++)
            send_item(-i, i == 4);
        drain();

        // overflow: a full store plus extra words, the marker among them
        for (int i = 0; i < MAX_ELEMENTS + 3; i++)
            send_item($urandom, i == MAX_ELEMENTS + 2);
        drain();

        // pressure: hold the sink while a set sorts and the next one waits
        hold_off = 1;
        fork
            begin
                send_set(10);
                send_set(3);
            end
            begin
                repeat (2000) @(posedge clk);
                @(negedge clk);
                hold_off = 0;
            end
        join
        drain();

        // random phases with changing idle mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 9 : 0;
            for (int s = 0; s < 3; s++)
                send_set($urandom_range(1, 10));
            drain();
        end

        $display("covered %0d sets and %0d sorted words,", board.sets, board.checked);
        $display("including a store overflow and a long sink stall");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("signed_word_sort_engine_test OK");
        else
            $display("signed_word_sort_engine_test NOT OK");
        $finish;
    end
endmodule
